// ===== src/mtirb_pkg.sv =====
// Package for the multi-target I2C register bank.
// Holds the command codes, default sizes and the control structs.
// No dependencies; used by every module of the block.
package mtirb_pkg;

  // Default sizes of the emulated target set and of each bank.
  localparam int TARGETS_DEFAULT    = 16;
  localparam int BANK_DEPTH_DEFAULT = 16;

  // Bus and host command codes carried by the command field.
  localparam logic [2:0] CMD_ADDR_WRITE = 3'd0;
  localparam logic [2:0] CMD_DATA_WRITE = 3'd1;
  localparam logic [2:0] CMD_ADDR_READ  = 3'd2;
  localparam logic [2:0] CMD_DATA_READ  = 3'd3;
  localparam logic [2:0] CMD_BUS_ERROR  = 3'd4;
  localparam logic [2:0] CMD_HOST_XCHG  = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // Clearing sweep writes one entry of each bank.
    logic accept;    // An input word is taken at this edge.
    logic load_out;  // Result goes into the output register.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;  // Last entry of the sweep is written at this edge.
  } ctrl_status_t;

endpackage

// ===== src/mtirb_ctrl.sv =====
// Controller of the multi-target I2C register bank.
// Sequences the clearing sweep, word acceptance and the output register.
// Depends on mtirb_pkg.
module mtirb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  mtirb_pkg::ctrl_status_t status,
  output mtirb_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } state_t;

  state_t state;
  logic   out_free;

  // The output register can take a word when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // Words are taken only while idle; the result leaves through its own register.
  assign in_stall     = (state != ST_IDLE);
  assign cmd.clear    = (state == ST_CLEAR);
  assign cmd.accept   = (state == ST_IDLE) && in_valid;
  assign cmd.load_out = (state == ST_ACCESS) && out_free;

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (status.clear_done) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/mtirb_dpath.sv =====
// Datapath of the multi-target I2C register bank.
// Holds the address and index registers, both bank memories and the result register.
// Depends on mtirb_pkg; driven by mtirb_ctrl.
module mtirb_dpath #(
  parameter int TARGETS    = mtirb_pkg::TARGETS_DEFAULT,
  parameter int BANK_DEPTH = mtirb_pkg::BANK_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mtirb_pkg::ctrl_cmd_t    cmd,
  output mtirb_pkg::ctrl_status_t status,
  input  logic                    cfg_write,
  input  logic [6:0]              cfg_data,
  input  logic [2:0]              command,
  input  logic [7:0]              bus_byte,
  input  logic [3:0]              host_target,
  input  logic [3:0]              host_register,
  input  logic [7:0]              host_value,
  output logic                    ack,
  output logic [7:0]              read_data,
  output logic [7:0]              host_read_value
);

  localparam int ENTRIES = TARGETS * BANK_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam int IW      = $clog2(BANK_DEPTH);
  localparam int MULW    = IW + 5;
  localparam logic [4:0]      TARGET_LIMIT = 5'(TARGETS);
  localparam logic [MULW-1:0] DEPTH_W      = MULW'(BANK_DEPTH);
  localparam logic [IW-1:0]   LAST_INDEX   = IW'(BANK_DEPTH - 1);
  localparam logic [AW-1:0]   LAST_ENTRY   = AW'(ENTRIES - 1);

  logic [6:0]    base_address;
  logic [7:0]    current_address;
  logic [IW-1:0] register_index;
  logic [AW-1:0] clear_count;

  logic [7:0] rx_mem [ENTRIES];
  logic [7:0] tx_mem [ENTRIES];
  logic [7:0] rx_q;
  logic [7:0] tx_q;

  logic pend_ack;
  logic pend_rd;
  logic pend_hrv;

  logic            is_addr_write, is_data_write, is_addr_read, is_data_read, is_host;
  logic            addr_match;
  logic [3:0]      bus_target;
  logic [IW-1:0]   bus_index;
  logic            bus_ok;
  logic            host_ok;
  logic [MULW-1:0] bus_slot_full;
  logic [MULW-1:0] host_slot_full;
  logic [AW-1:0]   bus_slot;
  logic [AW-1:0]   host_slot;
  logic [IW-1:0]   index_inc;
  logic            rx_we, rx_re, tx_we, tx_re;
  logic [AW-1:0]   rx_addr, tx_addr;
  logic [7:0]      rx_wdata, tx_wdata;

  // Command decode.
  assign is_addr_write = (command == mtirb_pkg::CMD_ADDR_WRITE);
  assign is_data_write = (command == mtirb_pkg::CMD_DATA_WRITE);
  assign is_addr_read  = (command == mtirb_pkg::CMD_ADDR_READ);
  assign is_data_read  = (command == mtirb_pkg::CMD_DATA_READ);
  assign is_host       = (command == mtirb_pkg::CMD_HOST_XCHG);

  // Address match: upper three address bits equal the base, low four pick the target.
  assign addr_match = (bus_byte[7:5] == base_address[6:4]) &&
                      ({1'b0, bus_byte[4:1]} < TARGET_LIMIT);

  // An address-with-read uses the new address and index zero right away.
  assign bus_target = is_addr_read ? bus_byte[4:1] : current_address[4:1];
  assign bus_index  = is_addr_read ? '0 : register_index;
  assign bus_ok     = ({1'b0, bus_target} < TARGET_LIMIT);

  assign host_ok = (base_address != 7'd0) &&
                   ({1'b0, host_target} < TARGET_LIMIT) &&
                   (MULW'(host_register) < DEPTH_W);

  // Bank slot is target times depth plus register.
  assign bus_slot_full  = MULW'(bus_target) * DEPTH_W + MULW'(bus_index);
  assign host_slot_full = MULW'(host_target) * DEPTH_W + MULW'(host_register);
  assign bus_slot       = bus_slot_full[AW-1:0];
  assign host_slot      = host_slot_full[AW-1:0];

  // Post-increment with wrap at the bank depth.
  assign index_inc = (bus_index == LAST_INDEX) ? '0 : bus_index + IW'(1);

  // Memory port control; the clearing sweep takes both ports.
  assign rx_we    = cmd.clear || (cmd.accept && is_data_write && bus_ok);
  assign rx_re    = cmd.accept && is_host && host_ok;
  assign rx_addr  = cmd.clear ? clear_count : (is_host ? host_slot : bus_slot);
  assign rx_wdata = cmd.clear ? 8'd0 : bus_byte;

  assign tx_we    = cmd.clear || (cmd.accept && is_host && host_ok);
  assign tx_re    = cmd.accept && ((is_addr_read && addr_match) || is_data_read) && bus_ok;
  assign tx_addr  = cmd.clear ? clear_count : (is_host ? host_slot : bus_slot);
  assign tx_wdata = cmd.clear ? 8'd0 : host_value;

  assign status.clear_done = cmd.clear && (clear_count == LAST_ENTRY);

  // Receive bank.
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_addr] <= rx_wdata;
    end
    if (rx_re) begin
      rx_q <= rx_mem[rx_addr];
    end
  end

  // Transmit bank.
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_addr] <= tx_wdata;
    end
    if (tx_re) begin
      tx_q <= tx_mem[tx_addr];
    end
  end

  // Base address, latched bus address, register index and clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address    <= 7'd0;
      current_address <= 8'd0;
      register_index  <= '0;
      clear_count     <= '0;
      pend_ack        <= 1'b0;
      pend_rd         <= 1'b0;
      pend_hrv        <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clear_count <= clear_count + AW'(1);
      end

      // A changed base address drops the latched bus address.
      if (cfg_write && (cfg_data != base_address)) begin
        base_address    <= cfg_data;
        current_address <= 8'd0;
      end

      if (cmd.accept) begin
        pend_ack <= ((is_addr_write || is_addr_read) && addr_match) ||
                    is_data_write || is_data_read;
        pend_rd  <= tx_re;
        pend_hrv <= rx_re;

        if (is_addr_write && addr_match) begin
          current_address <= bus_byte;
          register_index  <= '0;
        end else if (is_addr_read && addr_match) begin
          current_address <= bus_byte;
          register_index  <= index_inc;
        end else if (is_data_write || is_data_read) begin
          register_index <= index_inc;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ack             <= pend_ack;
      read_data       <= pend_rd ? tx_q : 8'd0;
      host_read_value <= pend_hrv ? rx_q : 8'd0;
    end
  end

endmodule

// ===== src/multi_target_i2c_register_bank_unit.sv =====
// Top level of the multi-target I2C register bank.
// Joins the controller mtirb_ctrl and the datapath mtirb_dpath; depends on mtirb_pkg.
//
//   channel  handshake                 payload
//   -------  ------------------------  ----------------------------------------------
//   input    in_valid / in_stall       command, bus_byte, host_target, host_register,
//                                      host_value
//   output   out_valid / out_stall     ack, read_data, host_read_value
//   config   cfg_write                 cfg_data (base address)
//
// Each word passes through the bank memory access as it is taken, then the loading of the result.
// The next word is taken while the result still waits in the output register.
// A result held by out_stall keeps the block in its access step until it drains.
// After reset a clearing sweep writes zero into all TARGETS * BANK_DEPTH entries of both banks
// (256 by default), one entry per cycle; no word is taken until it ends.
module multi_target_i2c_register_bank_unit #(
  parameter int TARGETS    = mtirb_pkg::TARGETS_DEFAULT,
  parameter int BANK_DEPTH = mtirb_pkg::BANK_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [7:0] bus_byte,
  input  logic [3:0] host_target,
  input  logic [3:0] host_register,
  input  logic [7:0] host_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       ack,
  output logic [7:0] read_data,
  output logic [7:0] host_read_value
);

  mtirb_pkg::ctrl_cmd_t    cmd;
  mtirb_pkg::ctrl_status_t status;

  // Controller.
  mtirb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath with both banks.
  mtirb_dpath #(
    .TARGETS    (TARGETS),
    .BANK_DEPTH (BANK_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .command         (command),
    .bus_byte        (bus_byte),
    .host_target     (host_target),
    .host_register   (host_register),
    .host_value      (host_value),
    .ack             (ack),
    .read_data       (read_data),
    .host_read_value (host_read_value)
  );

`ifndef SYNTH
  // An accepted word always occupies the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted on back-to-back cycles");

  // A new result only appears after an access step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an access step");

  // A host exchange result carries neither an acknowledge nor bus read data.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (host_read_value != 8'd0)) |-> (!ack && (read_data == 8'd0)))
    else $error("host exchange result mixed with bus result");
`endif

endmodule
